/* rtl/core/bba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Request and response types, function codes and map constants shared by the
// allocator core, its checker and the testbench scoreboard.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 32768;
   localparam int WORD_BITS          = 32;
   localparam int BIT_W              = $clog2(WORD_BITS);
   localparam int BLOCK_NUM_W        = 15;
   localparam int WORD_IDX_W         = BLOCK_NUM_W - BIT_W;
   localparam int CSR_W              = 11;

   localparam logic [CSR_W-1:0]     WORDS_RESET = CSR_W'(1024);
   localparam logic [WORD_BITS-1:0] FULL_WORD   = '1;

   localparam logic [1:0] FUNC_MARK_USED = 2'd0;
   localparam logic [1:0] FUNC_MARK_FREE = 2'd1;
   localparam logic [1:0] FUNC_TEST      = 2'd2;
   localparam logic [1:0] FUNC_FIND_FREE = 2'd3;

   typedef struct packed {
      logic [1:0]             func;
      logic [BLOCK_NUM_W-1:0] block_num;
   } req_type;

   typedef struct packed {
      logic                   block_used;
      logic [BLOCK_NUM_W-1:0] found_block;
      logic                   none_free;
   } rsp_type;

   function automatic logic [BIT_W-1:0] first_clear_bit(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] pos;
      int               b;
      pos = '0;
      for (b = WORD_BITS - 1; b >= 0; b--) begin
         if (!w[b]) begin
            pos = BIT_W'(b);
         end
      end
      return pos;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/bba_map_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap map memory
// Single write port, single read port synchronous memory with registered
// read data.
// ----------------------------------------------------------------------------
module bba_map_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] map_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/block_bitmap_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap allocator
// Keeps one used bit per memory block in a word-wide map memory and serves
// mark used, mark free, test and find-first-free requests.
//
// A request (req_payload) is taken on a clock edge with start high and busy
// low. Each request yields exactly one response: rsp_strobe is high for one
// cycle with rsp_payload valid. The receiver cannot stall the response.
// Mark and test read the map word at the accept edge; in the modify state
// a mark writes the changed word back and a test checks the bit. The
// response shows in the cycle after the modify state, with busy low.
// Find first free reads one map word per cycle from word 0, skipping full
// words, and searches at most the word count set by csr_wdata (capped at
// the map depth).
// csr_ready is always high; write the search word count only while idle.
// Reset restarts a clearing pass over all NUM_BLOCKS / 32 map words (1024 by
// default), one map word per cycle, with busy high; configuration writes
// are still taken during the pass.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_unit import bba_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_payload,
   output logic                  rsp_strobe,
   output rsp_type               rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   localparam int MapDepth = NUM_BLOCKS / WORD_BITS;
   localparam int AW       = (MapDepth > 1) ? $clog2(MapDepth) : 1;
   localparam int CW       = AW + 1;
   localparam int LW       = (CW > CSR_W) ? CW : CSR_W;
   localparam int IW       = (AW > WORD_IDX_W) ? AW : WORD_IDX_W;
   localparam int IW1      = IW + 1;
   localparam int FW       = (CW + BIT_W > BLOCK_NUM_W) ? CW + BIT_W : BLOCK_NUM_W;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_MODIFY = 4'b0100,
      ST_SEARCH = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CSR_W-1:0] words_used_ff;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   logic [IW-1:0]        new_word, cur_word;
   logic                 cur_inside;
   logic [WORD_BITS-1:0] bit_mask;
   logic [LW-1:0]        limit;
   logic                 scan_done;
   logic [CW-1:0]        idx_next;
   logic [FW-1:0]        found_wide;

   bba_map_ram #(
      .DEPTH  (MapDepth),
      .ADDR_W (AW),
      .DATA_W (WORD_BITS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign new_word   = IW'(req_payload.block_num[BLOCK_NUM_W-1:BIT_W]);
   assign cur_word   = IW'(req_ff.block_num[BLOCK_NUM_W-1:BIT_W]);
   assign cur_inside = IW1'(cur_word) < IW1'(MapDepth);
   assign bit_mask   = WORD_BITS'(1) << req_ff.block_num[BIT_W-1:0];
   assign limit      = (LW'(words_used_ff) > LW'(MapDepth)) ? LW'(MapDepth)
                                                            : LW'(words_used_ff);
   assign scan_done  = LW'(idx_ff) >= limit;
   assign idx_next   = idx_ff + 1'b1;
   assign found_wide = (FW'(idx_ff) << BIT_W) | FW'(first_clear_bit(rd_data));

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      wr_en         = 1'b0;
      wr_addr       = cur_word[AW-1:0];
      wr_data       = '0;
      rd_addr       = idx_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            if (idx_ff == CW'(MapDepth - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_IDLE: begin
            rd_addr = (req_payload.func == FUNC_FIND_FREE) ? '0 : new_word[AW-1:0];
            if (start) begin
               req_in   = req_payload;
               idx_in   = '0;
               state_in = (req_payload.func == FUNC_FIND_FREE) ? ST_SEARCH : ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            case (req_ff.func)
               FUNC_MARK_USED: begin
                  wr_en   = cur_inside;
                  wr_data = rd_data | bit_mask;
               end
               FUNC_MARK_FREE: begin
                  wr_en   = cur_inside;
                  wr_data = rd_data & ~bit_mask;
               end
               FUNC_TEST: begin
                  rsp_in.block_used = cur_inside & (|(rd_data & bit_mask));
               end
               default: begin
               end
            endcase
         end
         ST_SEARCH: begin
            if (scan_done) begin
               rsp_strobe_in    = 1'b1;
               rsp_in.none_free = 1'b1;
               state_in         = ST_IDLE;
            end else if (rd_data != FULL_WORD) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.found_block = found_wide[BLOCK_NUM_W-1:0];
               state_in           = ST_IDLE;
            end else begin
               idx_in  = idx_next;
               rd_addr = idx_next[AW-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         words_used_ff <= WORDS_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            words_used_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

/* rtl/core/bba_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block bitmap allocator checker
// Port-level properties of the allocator, attached to the allocator module by bind.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_payload
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while still busy");

   a_none_free_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.none_free |->
         rsp_payload.found_block == '0 && !rsp_payload.block_used)
      else $error("empty search result carries nonzero fields");

endmodule

bind block_bitmap_allocator_unit bba_checker u_checker (.*);
`default_nettype wire

/* tb/sv/bba_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block bitmap allocator checker
// Watches the request, response and register channels of the allocator,
// keeps its own copy of the usage map and search word count, predicts the
// response of every accepted request and compares each response field by
// field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module bba_scoreboard import bba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req_payload,
   input  logic             rsp_strobe,
   input  rsp_type          rsp_payload,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);

   localparam int MAP_DEPTH = NUM_BLOCKS_DEFAULT / WORD_BITS;

   logic [WORD_BITS-1:0] shadow_map [MAP_DEPTH];
   logic [CSR_W-1:0]     search_words;
   rsp_type              awaited_rsp [$];
   int                   mismatches = 0;

   function automatic rsp_type allocator_outcome(input req_type r);
      rsp_type               o;
      logic [WORD_IDX_W-1:0] w;
      logic [BIT_W-1:0]      b;
      int                    span;
      int                    i;
      int                    k;
      bit                    hit;
      o = '0;
      w = r.block_num[BLOCK_NUM_W-1:BIT_W];
      b = r.block_num[BIT_W-1:0];
      case (r.func)
         FUNC_MARK_USED: shadow_map[w][b] = 1'b1;
         FUNC_MARK_FREE: shadow_map[w][b] = 1'b0;
         FUNC_TEST:      o.block_used = shadow_map[w][b];
         FUNC_FIND_FREE: begin
            span = (int'(search_words) > MAP_DEPTH) ? MAP_DEPTH : int'(search_words);
            hit  = 1'b0;
            for (i = 0; i < span && !hit; i++) begin
               for (k = 0; k < WORD_BITS && !hit; k++) begin
                  if (!shadow_map[i][k]) begin
                     o.found_block = BLOCK_NUM_W'(i * WORD_BITS + k);
                     hit = 1'b1;
                  end
               end
            end
            o.none_free = !hit;
         end
      endcase
      return o;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (shadow_map[i]) shadow_map[i] = '0;
         search_words = WORDS_RESET;
         awaited_rsp.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_rsp.size() == 0) begin
               $error("response with no request outstanding: found_block %0d",
                      rsp_payload.found_block);
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("block_used", want.block_used, rsp_payload.block_used);
               check_field("found_block", want.found_block, rsp_payload.found_block);
               check_field("none_free", want.none_free, rsp_payload.none_free);
            end
         end
         if (csr_valid && csr_ready) search_words = csr_wdata;
         if (start && !busy) awaited_rsp.push_back(allocator_outcome(req_payload));
      end
      fail_count    <= mismatches;
      pending_count <= awaited_rsp.size();
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block bitmap allocator testbench
// Drives directed and random mark, free, test and find requests into the
// allocator in bursts with random gaps, many of them as allocate-then-mark
// sequences, across several search word counts including the extremes.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
   import bba_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 230;
   localparam int LOW_SPAN    = 255;
   localparam int ID_MAX      = 32767;
   localparam int REQ_W       = $bits(req_type);

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_payload;
   logic             rsp_strobe;
   rsp_type          rsp_payload;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_wdata;
   int               fail_count;
   int               pending_count;
   int               cycle_count = 0;
   int               issued      = 0;
   int               burst_left  = 0;

   block_bitmap_allocator_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   bba_scoreboard i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_strobe    (rsp_strobe),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // hold the request until it is taken, return at the next falling edge
   task automatic issue(input logic [1:0] f, input int id);
      start       <= 1'b1;
      req_payload <= '{func: f, block_num: BLOCK_NUM_W'(id)};
      do @(posedge clock); while (busy);
      issued++;
      @(negedge clock);
   endtask

   task automatic idle_gap(input int n);
      start       <= 1'b0;
      req_payload <= req_type'(REQ_W'($urandom));
      repeat (n) @(negedge clock);
   endtask

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle_gap($urandom_range(1, 7));
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (busy || pending_count != 0);
      @(negedge clock);
   endtask

   task automatic set_search_words(input int v);
      settle();
      csr_valid <= 1'b1;
      csr_wdata <= CSR_W'(v);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // find the lowest free block, then take it
   task automatic claim_block();
      rsp_type got;
      issue(FUNC_FIND_FREE, $urandom_range(0, ID_MAX));
      start <= 1'b0;
      do @(posedge clock); while (!rsp_strobe);
      got = rsp_payload;
      @(negedge clock);
      if (!got.none_free) begin
         issue(FUNC_MARK_USED, got.found_block);
         if ($urandom_range(0, 3) == 0) issue(FUNC_TEST, got.found_block);
         pace();
      end
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         claim_block();
      end else begin
         if (pick < 60) issue(FUNC_MARK_FREE, $urandom_range(0, LOW_SPAN));
         else if (pick < 75) issue(FUNC_TEST, $urandom_range(0, LOW_SPAN));
         else if (pick < 84) issue(FUNC_MARK_USED, $urandom_range(0, LOW_SPAN));
         else issue(2'($urandom), $urandom_range(0, ID_MAX));
         pace();
      end
   endtask

   initial begin
      int words [8];
      int p;
      int goal;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_wdata   = '0;
      words       = '{1024, 1, 2047, 2, 0, 3, 0, 1024};
      words[6]    = $urandom_range(0, 2047);
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      settle();

      issue(FUNC_TEST, 0);
      issue(FUNC_TEST, ID_MAX);
      issue(FUNC_MARK_USED, ID_MAX);
      issue(FUNC_TEST, ID_MAX);
      issue(FUNC_MARK_USED, 0);
      issue(FUNC_TEST, 0);
      issue(FUNC_FIND_FREE, ID_MAX);
      issue(FUNC_MARK_FREE, 0);
      issue(FUNC_FIND_FREE, 0);
      issue(FUNC_TEST, 'h2aaa);
      issue(FUNC_TEST, 'h5555);
      issue(FUNC_MARK_FREE, ID_MAX);
      issue(FUNC_TEST, ID_MAX);
      set_search_words(0);
      issue(FUNC_FIND_FREE, 0);
      set_search_words(2047);
      issue(FUNC_FIND_FREE, 0);

      for (p = 0; p < 8; p++) begin
         set_search_words(words[p]);
         goal = issued + PHASE_ITEMS;
         while (issued < goal) random_item();
      end

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/bba_pkg.sv
rtl/core/bba_map_ram.sv
rtl/core/block_bitmap_allocator_unit.sv
rtl/core/bba_checker.sv
tb/sv/bba_checker.sv
tb/sv/tb.sv
